### src/rwm_pkg.sv
package rwm_pkg;

	localparam int ZONES_DEFAULT = 4;
	localparam int TRACK_WORDS   = 5;
	localparam int ZONE_WORDS    = 2;
	localparam int DATA_W        = 16;
	localparam int CNT_W         = 3;
	localparam int CODE_SLOT_W   = 3;
	localparam int ZONE_NUM_W    = 8;
	localparam int CFG_IDX_W     = 4;

	localparam int TRACK_SLOT = 0;
	localparam int FIRE_SLOT  = 1;
	localparam int SLOT_ZONE0 = 2;

	localparam logic [DATA_W-1:0] STATUS_LIMIT_RST      = 16'd3;
	localparam logic [DATA_W-1:0] COORDINATE_LIMIT_RST  = 16'd63;
	localparam logic [DATA_W-1:0] BITMAP_LIMIT_RST      = 16'd15;
	localparam logic [DATA_W-1:0] TEMPERATURE_LIMIT_RST = 16'd1000;
	localparam logic [DATA_W-1:0] HUMIDITY_LIMIT_RST    = 16'd100;
	localparam logic [DATA_W-1:0] TRACK_ADDRESS_RST     = 16'd110;
	localparam logic [DATA_W-1:0] FIRE_ADDRESS_RST      = 16'd120;
	localparam logic [DATA_W-1:0] ZONE_BASE_ADDRESS_RST = 16'd100;

	typedef enum logic [1:0] {
		ACT_TRACK = 2'd0,
		ACT_FIRE  = 2'd1,
		ACT_ZONE  = 2'd2,
		ACT_TAKE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_ACCEPT = 2'd0,
		RES_REJECT = 2'd1,
		RES_EMPTY  = 2'd2,
		RES_WORD   = 2'd3
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATUS_LIMIT      = 4'd0,
		REG_COORDINATE_LIMIT  = 4'd1,
		REG_BITMAP_LIMIT      = 4'd2,
		REG_TEMPERATURE_LIMIT = 4'd3,
		REG_HUMIDITY_LIMIT    = 4'd4,
		REG_TRACK_ADDRESS     = 4'd5,
		REG_FIRE_ADDRESS      = 4'd6,
		REG_ZONE_BASE_ADDRESS = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_W-1:0] status_limit;
		logic [DATA_W-1:0] coordinate_limit;
		logic [DATA_W-1:0] bitmap_limit;
		logic [DATA_W-1:0] temperature_limit;
		logic [DATA_W-1:0] humidity_limit;
		logic [DATA_W-1:0] track_address;
		logic [DATA_W-1:0] fire_address;
		logic [DATA_W-1:0] zone_base_address;
	} cfg_regs_t;

	typedef logic [TRACK_WORDS-1:0][DATA_W-1:0] words_t;

	typedef struct packed {
		logic              en;
		logic [DATA_W-1:0] start;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  nw;
		words_t            words;
	} slot_wr_t;

	typedef struct packed {
		logic accept;
		logic fire_we;
		logic fire_val;
		logic shut;
	} post_t;

endpackage

### src/register_write_mailbox.sv
// Register write mailbox: coalesces pending register writes, one slot per
// display kind (track, fire, one per zone); the latest post to a slot wins.
// Command channel: an item is taken at a clock edge with start high and busy
// low. action selects post track, post fire, post zone or take next.
// Results: each result sits on the result ports for one cycle with strobe
// high; the receiver cannot stall, so nothing waits on the output side.
// Result path: an accepted item is registered in stage one, and the result
// register loads from stage one in the cycle after the accepting edge.
// Posts may be issued every cycle while busy is low.
// A take holds busy while its slot is drained, one word per cycle through
// the slot read mux: busy stays high while the take is in stage one and,
// for a write of more than one word, until its last word is read.
// Config: write channel cfg_valid/cfg_ready/cfg_index/cfg_data, cfg_ready
// always high; write only while idle. Unknown indexes are ignored.
// Reset: asynchronous, active low. Limits and addresses return to their
// defaults, no slot is pending, the drain cursor is at the track slot and
// the fire latch is clear. Slot contents are not cleared.
module register_write_mailbox #(
	parameter int ZONES = rwm_pkg::ZONES_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      action,
	input  logic [rwm_pkg::DATA_W-1:0]      track_status,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_ax,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_ay,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_bx,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_by,
	input  logic [rwm_pkg::DATA_W-1:0]      fire_zones,
	input  logic [rwm_pkg::ZONE_NUM_W-1:0]  zone_number,
	input  logic [rwm_pkg::DATA_W-1:0]      temperature_x10,
	input  logic [rwm_pkg::DATA_W-1:0]      humidity_pct,
	output logic                            strobe,
	output logic [1:0]                      result_code,
	output logic [rwm_pkg::CODE_SLOT_W-1:0] slot_index,
	output logic [rwm_pkg::DATA_W-1:0]      start_address,
	output logic [rwm_pkg::CNT_W-1:0]       word_count,
	output logic [rwm_pkg::CNT_W-1:0]       word_index,
	output logic [rwm_pkg::DATA_W-1:0]      word_value,
	output logic                            last,
	output logic                            fire_active,
	output logic                            shutter_close,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rwm_pkg::DATA_W-1:0]      cfg_data
);
	import rwm_pkg::*;

	localparam int NSLOTS = 2 + ZONES;
	localparam int SLOT_W = $clog2(NSLOTS);

	cfg_regs_t regs;

	logic                  valid_s1;
	action_t               action_s1;
	logic [DATA_W-1:0]     track_status_s1;
	logic [DATA_W-1:0]     coord_ax_s1;
	logic [DATA_W-1:0]     coord_ay_s1;
	logic [DATA_W-1:0]     coord_bx_s1;
	logic [DATA_W-1:0]     coord_by_s1;
	logic [DATA_W-1:0]     fire_zones_s1;
	logic [ZONE_NUM_W-1:0] zone_number_s1;
	logic [DATA_W-1:0]     temperature_x10_s1;
	logic [DATA_W-1:0]     humidity_pct_s1;

	logic              drain_q;
	logic [SLOT_W-1:0] drain_slot_q;
	logic [CNT_W-1:0]  drain_k_q;
	logic [CNT_W-1:0]  drain_n_q;
	logic              fire_latch_q;

	logic                   strobe_q;
	result_t                code_q;
	logic [CODE_SLOT_W-1:0] slot_q;
	logic [DATA_W-1:0]      start_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [DATA_W-1:0]      value_q;
	logic                   last_q;
	logic                   shut_q;

	slot_wr_t          wr;
	logic [SLOT_W-1:0] wr_slot;
	post_t             post;
	logic              is_take;
	logic              take_en;
	logic              found;
	logic [SLOT_W-1:0] found_slot;
	logic [SLOT_W-1:0] rd_slot;
	logic [CNT_W-1:0]  rd_idx;
	logic [DATA_W-1:0] rd_start;
	logic [CNT_W-1:0]  rd_count;
	logic [DATA_W-1:0] rd_word;
	logic              drain_end;
	logic              accept;

	rwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	rwm_check #(.ZONES(ZONES)) u_check (
		.valid           (valid_s1),
		.action          (action_s1),
		.track_status    (track_status_s1),
		.coord_ax        (coord_ax_s1),
		.coord_ay        (coord_ay_s1),
		.coord_bx        (coord_bx_s1),
		.coord_by        (coord_by_s1),
		.fire_zones      (fire_zones_s1),
		.zone_number     (zone_number_s1),
		.temperature_x10 (temperature_x10_s1),
		.humidity_pct    (humidity_pct_s1),
		.regs            (regs),
		.fire_latch      (fire_latch_q),
		.wr              (wr),
		.wr_slot         (wr_slot),
		.post            (post)
	);

	rwm_store #(.ZONES(ZONES)) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.wr_slot    (wr_slot),
		.take_en    (take_en),
		.found      (found),
		.found_slot (found_slot),
		.rd_slot    (rd_slot),
		.rd_idx     (rd_idx),
		.rd_start   (rd_start),
		.rd_count   (rd_count),
		.rd_word    (rd_word)
	);

	assign is_take   = valid_s1 && (action_s1 == ACT_TAKE);
	assign take_en   = is_take && found;
	assign drain_end = drain_k_q == drain_n_q - CNT_W'(1);
	assign busy      = is_take || (drain_q && !drain_end);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign rd_slot = drain_q ? drain_slot_q : found_slot;
	assign rd_idx  = drain_q ? drain_k_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			drain_q      <= 1'b0;
			fire_latch_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			strobe_q <= valid_s1 || drain_q;
			if (valid_s1 && post.fire_we)
				fire_latch_q <= post.fire_val;
			if (take_en)
				drain_q <= rd_count != CNT_W'(1);
			else if (drain_q && drain_end)
				drain_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1          <= action_t'(action);
			track_status_s1    <= track_status;
			coord_ax_s1        <= coord_ax;
			coord_ay_s1        <= coord_ay;
			coord_bx_s1        <= coord_bx;
			coord_by_s1        <= coord_by;
			fire_zones_s1      <= fire_zones;
			zone_number_s1     <= zone_number;
			temperature_x10_s1 <= temperature_x10;
			humidity_pct_s1    <= humidity_pct;
		end
		if (take_en) begin
			drain_slot_q <= found_slot;
			drain_k_q    <= CNT_W'(1);
			drain_n_q    <= rd_count;
		end else if (drain_q) begin
			drain_k_q <= drain_k_q + CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			slot_q  <= '0;
			start_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			value_q <= '0;
			last_q  <= 1'b1;
			shut_q  <= 1'b0;
			if (is_take) begin
				if (found) begin
					code_q  <= RES_WORD;
					slot_q  <= CODE_SLOT_W'(rd_slot);
					start_q <= rd_start;
					count_q <= rd_count;
					value_q <= rd_word;
					last_q  <= rd_count == CNT_W'(1);
				end else begin
					code_q <= RES_EMPTY;
				end
			end else begin
				code_q <= post.accept ? RES_ACCEPT : RES_REJECT;
				shut_q <= post.shut;
			end
		end else if (drain_q) begin
			code_q  <= RES_WORD;
			slot_q  <= CODE_SLOT_W'(rd_slot);
			start_q <= rd_start;
			count_q <= drain_n_q;
			idx_q   <= drain_k_q;
			value_q <= rd_word;
			last_q  <= drain_end;
			shut_q  <= 1'b0;
		end
	end

	assign strobe        = strobe_q;
	assign result_code   = code_q;
	assign slot_index    = slot_q;
	assign start_address = start_q;
	assign word_count    = count_q;
	assign word_index    = idx_q;
	assign word_value    = value_q;
	assign last          = last_q;
	assign fire_active   = fire_latch_q;
	assign shutter_close = shut_q;

`ifndef ASSERT_OFF
	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q && (code_q == RES_WORD))
		else $error("drain stopped before its last word");

	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> strobe_q)
		else $error("item in stage one gave no result");

	a_shut_fire: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && shut_q |-> fire_latch_q)
		else $error("shutter close without fire latch");

	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (code_q == RES_WORD) |-> idx_q < count_q)
		else $error("word index outside write");

	a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q && !drain_end |-> !accept)
		else $error("item taken during a drain");
`endif

endmodule

### src/rwm_cfg.sv
module rwm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rwm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rwm_pkg::DATA_W-1:0]     wr_data,
	output rwm_pkg::cfg_regs_t             regs
);
	import rwm_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.status_limit      <= STATUS_LIMIT_RST;
			regs_q.coordinate_limit  <= COORDINATE_LIMIT_RST;
			regs_q.bitmap_limit      <= BITMAP_LIMIT_RST;
			regs_q.temperature_limit <= TEMPERATURE_LIMIT_RST;
			regs_q.humidity_limit    <= HUMIDITY_LIMIT_RST;
			regs_q.track_address     <= TRACK_ADDRESS_RST;
			regs_q.fire_address      <= FIRE_ADDRESS_RST;
			regs_q.zone_base_address <= ZONE_BASE_ADDRESS_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_STATUS_LIMIT:      regs_q.status_limit      <= wr_data;
				REG_COORDINATE_LIMIT:  regs_q.coordinate_limit  <= wr_data;
				REG_BITMAP_LIMIT:      regs_q.bitmap_limit      <= wr_data;
				REG_TEMPERATURE_LIMIT: regs_q.temperature_limit <= wr_data;
				REG_HUMIDITY_LIMIT:    regs_q.humidity_limit    <= wr_data;
				REG_TRACK_ADDRESS:     regs_q.track_address     <= wr_data;
				REG_FIRE_ADDRESS:      regs_q.fire_address      <= wr_data;
				REG_ZONE_BASE_ADDRESS: regs_q.zone_base_address <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

### src/rwm_check.sv
module rwm_check #(
	parameter int ZONES = rwm_pkg::ZONES_DEFAULT,
	localparam int NSLOTS = 2 + ZONES,
	localparam int SLOT_W = $clog2(NSLOTS)
) (
	input  logic                            valid,
	input  rwm_pkg::action_t                action,
	input  logic [rwm_pkg::DATA_W-1:0]      track_status,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_ax,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_ay,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_bx,
	input  logic [rwm_pkg::DATA_W-1:0]      coord_by,
	input  logic [rwm_pkg::DATA_W-1:0]      fire_zones,
	input  logic [rwm_pkg::ZONE_NUM_W-1:0]  zone_number,
	input  logic [rwm_pkg::DATA_W-1:0]      temperature_x10,
	input  logic [rwm_pkg::DATA_W-1:0]      humidity_pct,
	input  rwm_pkg::cfg_regs_t              regs,
	input  logic                            fire_latch,
	output rwm_pkg::slot_wr_t               wr,
	output logic [SLOT_W-1:0]               wr_slot,
	output rwm_pkg::post_t                  post
);
	import rwm_pkg::*;

	logic                  trk_ok;
	logic                  zone_ok;
	logic [ZONE_NUM_W-1:0] zone_m1;

	assign trk_ok = (track_status <= regs.status_limit) &&
	                (coord_ax <= regs.coordinate_limit) &&
	                (coord_ay <= regs.coordinate_limit) &&
	                (coord_bx <= regs.coordinate_limit) &&
	                (coord_by <= regs.coordinate_limit);

	assign zone_ok = (zone_number != '0) && (zone_number <= ZONE_NUM_W'(ZONES)) &&
	                 (temperature_x10 <= regs.temperature_limit) &&
	                 (humidity_pct <= regs.humidity_limit);

	assign zone_m1 = zone_number - ZONE_NUM_W'(1);

	always_comb begin
		wr       = '0;
		wr_slot  = SLOT_W'(TRACK_SLOT);
		post     = '0;
		case (action)
			ACT_TRACK: begin
				post.accept = trk_ok;
				wr.en       = valid && trk_ok;
				wr.start    = regs.track_address;
				wr.count    = (track_status == '0) ? CNT_W'(1) : CNT_W'(TRACK_WORDS);
				wr.nw       = CNT_W'(TRACK_WORDS);
				wr.words    = {coord_by, coord_bx, coord_ay, coord_ax, track_status};
			end
			ACT_FIRE: begin
				post.accept   = fire_zones <= regs.bitmap_limit;
				post.fire_we  = valid && post.accept;
				post.fire_val = fire_zones != '0;
				post.shut     = post.accept && post.fire_val && !fire_latch;
				wr.en         = valid && post.accept;
				wr.start      = regs.fire_address;
				wr.count      = CNT_W'(1);
				wr.nw         = CNT_W'(1);
				wr.words[0]   = fire_zones;
				wr_slot       = SLOT_W'(FIRE_SLOT);
			end
			ACT_ZONE: begin
				post.accept = zone_ok;
				wr.en       = valid && zone_ok;
				wr.start    = DATA_W'(regs.zone_base_address +
				              DATA_W'(DATA_W'(zone_m1) * DATA_W'(ZONE_WORDS)));
				wr.count    = CNT_W'(ZONE_WORDS);
				wr.nw       = CNT_W'(ZONE_WORDS);
				wr.words[0] = temperature_x10;
				wr.words[1] = humidity_pct;
				wr_slot     = SLOT_W'(zone_m1 + ZONE_NUM_W'(SLOT_ZONE0));
			end
			default: ;
		endcase
	end

endmodule

### src/rwm_store.sv
module rwm_store #(
	parameter int ZONES = rwm_pkg::ZONES_DEFAULT,
	localparam int NSLOTS = 2 + ZONES,
	localparam int SLOT_W = $clog2(NSLOTS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rwm_pkg::slot_wr_t            wr,
	input  logic [SLOT_W-1:0]            wr_slot,
	input  logic                         take_en,
	output logic                         found,
	output logic [SLOT_W-1:0]            found_slot,
	input  logic [SLOT_W-1:0]            rd_slot,
	input  logic [rwm_pkg::CNT_W-1:0]    rd_idx,
	output logic [rwm_pkg::DATA_W-1:0]   rd_start,
	output logic [rwm_pkg::CNT_W-1:0]    rd_count,
	output logic [rwm_pkg::DATA_W-1:0]   rd_word
);
	import rwm_pkg::*;

	logic [DATA_W-1:0] start_q [NSLOTS];
	logic [CNT_W-1:0]  count_q [NSLOTS];
	words_t            words_q [NSLOTS];
	logic [NSLOTS-1:0] pending_q;
	logic [SLOT_W-1:0] cursor_q;

	// round-robin search from the cursor; lowest distance wins
	always_comb begin
		logic [SLOT_W:0] s;
		found      = 1'b0;
		found_slot = '0;
		for (int i = NSLOTS - 1; i >= 0; i--) begin
			s = {1'b0, cursor_q} + (SLOT_W + 1)'(i);
			if (s >= (SLOT_W + 1)'(NSLOTS))
				s = s - (SLOT_W + 1)'(NSLOTS);
			if (pending_q[s[SLOT_W-1:0]]) begin
				found      = 1'b1;
				found_slot = s[SLOT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			cursor_q  <= '0;
		end else begin
			if (wr.en)
				pending_q[wr_slot] <= 1'b1;
			if (take_en) begin
				pending_q[found_slot] <= 1'b0;
				cursor_q <= (found_slot == SLOT_W'(NSLOTS - 1)) ? '0 :
				            found_slot + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			start_q[wr_slot] <= wr.start;
			count_q[wr_slot] <= wr.count;
			for (int i = 0; i < TRACK_WORDS; i++) begin
				if (CNT_W'(i) < wr.nw)
					words_q[wr_slot][i] <= wr.words[i];
			end
		end
	end

	assign rd_start = start_q[rd_slot];
	assign rd_count = count_q[rd_slot];
	assign rd_word  = words_q[rd_slot][rd_idx];

endmodule
